/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the slot pool.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_ON_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("slot pool assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("slot pool assertion failed during or after reset");

`endif

/* rtl/rcsp_pkg.sv */
// Types and constants of the reference-counted slot pool.
// Used by the interfaces, the core, the top level and the checker.
`timescale 1ns / 1ps

package rcsp_pkg;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RETAIN  = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned REFS_W  = 8;
  localparam int unsigned USE_W   = 5;
  localparam int unsigned STAT_W  = 32;
  localparam logic [REFS_W-1:0] REFS_MAX = 8'hFF;

  // One operation request.
  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic              in_pool;
    logic              foreign_dynamic;
  } in_word_t;

  // One operation result with the statistics after it.
  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] granted_slot;
    logic [REFS_W-1:0] count_after;
    logic [USE_W-1:0]  slots_in_use;
    logic [USE_W-1:0]  peak_in_use;
    logic [STAT_W-1:0] grants_total;
    logic [STAT_W-1:0] grant_failures;
    logic [STAT_W-1:0] frees_total;
    logic [STAT_W-1:0] bad_releases;
  } out_word_t;

endpackage

/* rtl/rcsp_in_if.sv */
// Valid/ready channel that carries operation requests.
// Depends on rcsp_pkg for the word type.
`timescale 1ns / 1ps

interface rcsp_in_if import rcsp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/rcsp_out_if.sv */
// Valid/ready channel that carries operation results.
// Depends on rcsp_pkg for the word type.
`timescale 1ns / 1ps

interface rcsp_out_if import rcsp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/refcounted_slot_pool.sv */
// Top level of the reference-counted slot pool.
// Depends on rcsp_pkg, rcsp_in_if, rcsp_out_if and rcsp_core.
//
// Usage:
//   in_chan carries one request word per handshake: allocate, retain or
//   release, with a slot handle. out_chan returns exactly one result word
//   per request, in request order, with the status and the statistics
//   counters as they stand after that request.
//   A request is registered when accepted, evaluated against the pool
//   state once the result register is empty or being taken, and its result
//   is registered at the same edge that commits the state change.
//   Throughput is one request per cycle while the receiver takes each
//   result: the free-slot search is a single find-first-zero over the busy
//   bitmap and every update is one step.
//   When the receiver stalls, the result register holds its word and the
//   request register can still take one more request; after that in_ready
//   drops until the result is taken.
//   Reset (rst_n low, synchronous) frees every slot, clears all counters
//   and empties both registers.
`timescale 1ns / 1ps

module refcounted_slot_pool import rcsp_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input logic          clk,
  input logic          rst_n,
  rcsp_in_if.sink      in_chan,
  rcsp_out_if.source   out_chan
);

  logic      req_v_r, req_v_nxt;
  in_word_t  req_word_r;
  logic      res_v_r, res_v_nxt;
  out_word_t res_word_r;
  out_word_t step_res;
  logic      in_fire;
  logic      advance;

  // Handshake control.
  assign advance         = req_v_r && (!res_v_r || out_chan.ready);
  assign in_chan.ready   = !req_v_r || advance;
  assign in_fire         = in_chan.valid && in_chan.ready;
  assign req_v_nxt       = in_fire ? 1'b1 : (advance ? 1'b0 : req_v_r);
  assign res_v_nxt       = advance ? 1'b1 : (out_chan.ready ? 1'b0 : res_v_r);
  assign out_chan.valid  = res_v_r;
  assign out_chan.data   = res_word_r;

  rcsp_core #(.SLOTS(SLOTS)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .op      (req_word_r),
    .res     (step_res)
  );

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      req_v_r <= req_v_nxt;
      res_v_r <= res_v_nxt;
    end
  end

  // Request and result words.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_word_r <= in_chan.data;
    end
    if (advance) begin
      res_word_r <= step_res;
    end
  end

endmodule

/* rtl/rcsp_ffz.sv */
// Find-first-zero over the slot busy bitmap: lowest free slot.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps

module rcsp_ffz #(
  parameter int unsigned SLOTS = 16,
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic [SLOTS-1:0] busy,
  output logic             found,
  output logic [IDX_W-1:0] idx
);

  // Scan from the top so that the lowest free slot is the last one taken.
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
  end

endmodule

/* rtl/rcsp_core.sv */
// Slot pool state: busy bits, reference counts and statistics counters.
// Depends on rcsp_pkg and rcsp_ffz.
`timescale 1ns / 1ps

module rcsp_core import rcsp_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_word_t  op,
  output out_word_t res
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned EXT_W = 9;

  logic [SLOTS-1:0]  busy_r, busy_nxt;
  logic [REFS_W-1:0] refs_r [SLOTS];
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]  peak_r, peak_nxt;
  logic [STAT_W-1:0] grants_r, grants_nxt;
  logic [STAT_W-1:0] fails_r, fails_nxt;
  logic [STAT_W-1:0] frees_r, frees_nxt;
  logic [STAT_W-1:0] bad_r, bad_nxt;

  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [EXT_W-1:0]  slot_ext;
  logic [EXT_W-1:0]  grant_ext;
  logic [IDX_W-1:0]  slot_idx;
  logic              slot_in_range;
  logic              slot_busy;
  logic [REFS_W-1:0] cur_refs;
  logic [REFS_W-1:0] dec_refs;

  // Write-back of one reference count.
  logic              refs_we;
  logic [IDX_W-1:0]  refs_waddr;
  logic [REFS_W-1:0] refs_wdata;

  rcsp_ffz #(.SLOTS(SLOTS)) u_ffz (
    .busy  (busy_r),
    .found (free_found),
    .idx   (free_idx)
  );

  // Addressed slot: a handle beyond the pool reads as a free slot.
  assign slot_ext      = EXT_W'(op.slot);
  assign slot_idx      = slot_ext[IDX_W-1:0];
  assign slot_in_range = slot_ext < EXT_W'(SLOTS);
  assign slot_busy     = slot_in_range && busy_r[slot_idx];
  // A free slot reads as count zero, so its stored count is not read.
  assign cur_refs      = slot_busy ? refs_r[slot_idx] : '0;
  assign dec_refs      = cur_refs - 1'b1;
  assign grant_ext     = EXT_W'(free_idx);

  // Operation decode and next state.
  always_comb begin
    busy_nxt   = busy_r;
    used_nxt   = used_r;
    grants_nxt = grants_r;
    fails_nxt  = fails_r;
    frees_nxt  = frees_r;
    bad_nxt    = bad_r;
    refs_we    = 1'b0;
    refs_waddr = slot_idx;
    refs_wdata = '0;
    res        = '0;

    case (kind_t'(op.kind))
      KIND_ALLOC: begin
        if (free_found) begin
          busy_nxt[free_idx] = 1'b1;
          refs_we            = 1'b1;
          refs_waddr         = free_idx;
          refs_wdata         = REFS_W'(1);
          used_nxt           = used_r + 1'b1;
          grants_nxt         = grants_r + 1'b1;
          res.ok             = 1'b1;
          res.granted_slot   = grant_ext[SLOT_W-1:0];
          res.count_after    = REFS_W'(1);
        end else begin
          fails_nxt = fails_r + 1'b1;
        end
      end
      KIND_RETAIN: begin
        if (op.in_pool && slot_in_range) begin
          if (slot_busy && cur_refs != REFS_MAX) begin
            refs_we         = 1'b1;
            refs_wdata      = cur_refs + 1'b1;
            res.ok          = 1'b1;
            res.count_after = cur_refs + 1'b1;
          end else begin
            res.count_after = cur_refs;
          end
        end
      end
      KIND_RELEASE: begin
        if (!op.in_pool) begin
          // Foreign handle: only a static or null handle may be released.
          res.ok = !op.foreign_dynamic;
        end else if (!slot_in_range) begin
          bad_nxt = bad_r + 1'b1;
        end else if (!slot_busy || cur_refs == '0) begin
          bad_nxt         = bad_r + 1'b1;
          res.count_after = cur_refs;
        end else begin
          refs_we         = 1'b1;
          refs_wdata      = dec_refs;
          res.ok          = 1'b1;
          res.count_after = dec_refs;
          if (dec_refs == '0) begin
            busy_nxt[slot_idx] = 1'b0;
            used_nxt           = used_r - 1'b1;
            frees_nxt          = frees_r + 1'b1;
          end
        end
      end
      default: begin
        // Unused operation code: no state change, ok stays low.
      end
    endcase

    peak_nxt = (used_nxt > peak_r) ? used_nxt : peak_r;

    res.slots_in_use   = USE_W'(used_nxt);
    res.peak_in_use    = USE_W'(peak_nxt);
    res.grants_total   = grants_nxt;
    res.grant_failures = fails_nxt;
    res.frees_total    = frees_nxt;
    res.bad_releases   = bad_nxt;
  end

  // Control state and statistics.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= '0;
      used_r   <= '0;
      peak_r   <= '0;
      grants_r <= '0;
      fails_r  <= '0;
      frees_r  <= '0;
      bad_r    <= '0;
    end else if (step_en) begin
      busy_r   <= busy_nxt;
      used_r   <= used_nxt;
      peak_r   <= peak_nxt;
      grants_r <= grants_nxt;
      fails_r  <= fails_nxt;
      frees_r  <= frees_nxt;
      bad_r    <= bad_nxt;
    end
  end

  // Reference counts; an entry is only meaningful while its busy bit is set.
  always_ff @(posedge clk) begin
    if (step_en && refs_we) begin
      refs_r[refs_waddr] <= refs_wdata;
    end
  end

endmodule

/* rtl/rcsp_checker.sv */
// Port-level checks on the result channel of the slot pool, and its bind.
// Depends on rcsp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rcsp_checker import rcsp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // No result word is shown in the cycle after reset.
  `ASSERT_ALWAYS(a_no_word_after_reset, clk, !rst_n |=> !out_valid)

  // A stalled result word holds.
  `ASSERT_ON_CLK(a_stall_holds, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // Slots in use never exceed the recorded peak.
  `ASSERT_ON_CLK(a_use_below_peak, clk, rst_n, out_valid |-> out_data.slots_in_use <= out_data.peak_in_use)

  // A granted slot is only reported by a successful operation.
  `ASSERT_ON_CLK(a_grant_needs_ok, clk, rst_n, out_valid && out_data.granted_slot != '0 |-> out_data.ok)

endmodule

bind refcounted_slot_pool rcsp_checker u_rcsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);
